[hdl/gbfs_pkg.sv]
// Shared types, codes and helpers of the grid breadth-first distance core.
package gbfs_pkg;

	localparam int CMD_W     = 2;
	localparam int COORD_W   = 6;
	localparam int DIST_W    = 12;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int GRID_SZ_W = 9;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

	localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               wall;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              reachable;
	} out_item_t;

	typedef struct packed {
		logic              visited;
		logic [DIST_W-1:0] steps;
	} vd_entry_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT
	} dir_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_START,
		S_POP,
		S_FETCH,
		S_NB,
		S_QWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic pending;
		logic push;
	} nb_stat_t;

	function automatic logic [GRID_SZ_W-1:0] used_size(input logic [CFG_W-1:0] v,
		input logic [GRID_SZ_W-1:0] limit);
		logic [GRID_SZ_W-1:0] ext;
		ext = GRID_SZ_W'(v);
		if (ext == '0)
			return GRID_SZ_W'(1);
		if (ext > limit)
			return limit;
		return ext;
	endfunction

endpackage

[hdl/gbfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[hdl/gbfs_nbr.sv]
// Neighbor address generator and visit check of the search engine.
module gbfs_nbr #(
	parameter int ROW_W = 6,
	parameter int COL_W = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            issue,
	input  logic [ROW_W+COL_W-1:0]          cur_addr,
	input  gbfs_pkg::dir_t                  dir,
	input  logic [gbfs_pkg::GRID_SZ_W-1:0]  rows_used,
	input  logic [gbfs_pkg::GRID_SZ_W-1:0]  cols_used,
	input  logic                            wall_bit,
	input  logic                            visited_bit,
	output logic [ROW_W+COL_W-1:0]          rd_addr,
	output logic [ROW_W+COL_W-1:0]          push_addr,
	output gbfs_pkg::nb_stat_t              stat
);

	localparam int AW = ROW_W + COL_W;

	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] nb_row;
	logic [COL_W-1:0] nb_col;
	logic             in_bounds;
	logic             chk_v_q;
	logic [AW-1:0]    chk_addr_q;

	assign cur_row = cur_addr[AW-1:COL_W];
	assign cur_col = cur_addr[COL_W-1:0];

	always_comb begin
		nb_row    = cur_row;
		nb_col    = cur_col;
		in_bounds = 1'b0;
		unique case (dir)
			gbfs_pkg::DIR_UP: begin
				in_bounds = (cur_row != '0);
				nb_row    = cur_row - 1'b1;
			end
			gbfs_pkg::DIR_RIGHT: begin
				in_bounds = (gbfs_pkg::GRID_SZ_W'(cur_col) + gbfs_pkg::GRID_SZ_W'(1)) < cols_used;
				nb_col    = cur_col + 1'b1;
			end
			gbfs_pkg::DIR_DOWN: begin
				in_bounds = (gbfs_pkg::GRID_SZ_W'(cur_row) + gbfs_pkg::GRID_SZ_W'(1)) < rows_used;
				nb_row    = cur_row + 1'b1;
			end
			gbfs_pkg::DIR_LEFT: begin
				in_bounds = (cur_col != '0);
				nb_col    = cur_col - 1'b1;
			end
		endcase
	end

	assign rd_addr = {nb_row, nb_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_q <= 1'b0;
		end else begin
			chk_v_q <= issue && in_bounds;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && in_bounds)
			chk_addr_q <= rd_addr;
	end

	assign push_addr     = chk_addr_q;
	assign stat.rd_en    = issue && in_bounds;
	assign stat.pending  = chk_v_q;
	assign stat.push     = chk_v_q && !visited_bit && !wall_bit;

endmodule

[hdl/grid_bfs_distance_core.sv]
// Top level of the grid breadth-first distance core: sequencer, memories and result register.
//
// A grid of up to MAX_ROWS x MAX_COLS cells holds one wall bit per cell; a search floods from a
// start cell with a cell queue, trying up, right, down and left, and stores a distance (saturating
// at 4095) for each open cell reached. After reset the core sweeps its wall and visited memories,
// one entry a cycle, over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (4096 by default)
// before it takes the first item; configuration writes are taken at any time. A wall write
// passes through the done state to a result, and a query inside the grid first reads the
// visited memory in a wait state. A search first sweeps the whole visited memory, as the reset
// sweep does, then handles each reached cell with one queue read and four neighbor probes issued
// one per cycle through a single read port of the wall and visited memories, each checked the
// cycle after. The core takes one item at a time; a finished result waits in an output register.
module grid_bfs_distance_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  gbfs_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output gbfs_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbfs_pkg::CFG_W-1:0]         cfg_data
);

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int CELLS  = 2 ** ADDR_W;
	localparam int FIFO_W = ADDR_W + gbfs_pkg::DIST_W;
	localparam int VD_W   = $bits(gbfs_pkg::vd_entry_t);

	gbfs_pkg::state_t state_q, state_d;

	logic [gbfs_pkg::CFG_W-1:0]     rows_q, cols_q;
	logic [gbfs_pkg::GRID_SZ_W-1:0] rows_used, cols_used;
	logic [ADDR_W-1:0]              clr_q;
	logic [ADDR_W:0]                head_q, tail_q;
	gbfs_pkg::dir_t                 dir_q;
	logic                           start_ok_q;
	logic [ADDR_W-1:0]              start_addr_q;
	logic [ADDR_W-1:0]              cur_addr_q;
	logic [gbfs_pkg::DIST_W-1:0]    nd_q;
	gbfs_pkg::out_item_t            res_q;
	logic                           out_valid_q;
	gbfs_pkg::out_item_t            out_data_q;

	logic                           in_accept;
	logic [gbfs_pkg::GRID_SZ_W-1:0] in_row_ext, in_col_ext;
	logic                           in_store, in_grid;
	logic [ADDR_W-1:0]              in_addr;
	logic                           clr_done;
	logic                           fifo_empty;
	logic                           pop_go;
	logic                           out_free;
	logic [gbfs_pkg::DIST_W-1:0]    fifo_dist;
	logic [gbfs_pkg::DIST_W-1:0]    next_dist;

	logic                           wall_we, wall_re, wall_wdata, wall_rdata;
	logic [ADDR_W-1:0]              wall_waddr, wall_raddr;
	logic                           vd_we, vd_re;
	logic [ADDR_W-1:0]              vd_waddr, vd_raddr;
	gbfs_pkg::vd_entry_t            vd_wdata, vd_rdata;
	logic                           fifo_we, fifo_re;
	logic [ADDR_W-1:0]              fifo_waddr, fifo_raddr;
	logic [FIFO_W-1:0]              fifo_wdata, fifo_rdata;

	logic [ADDR_W-1:0]              nb_addr, push_addr;
	gbfs_pkg::nb_stat_t             nb;

	assign rows_used = gbfs_pkg::used_size(rows_q, gbfs_pkg::GRID_SZ_W'(MAX_ROWS));
	assign cols_used = gbfs_pkg::used_size(cols_q, gbfs_pkg::GRID_SZ_W'(MAX_COLS));

	assign in_ready   = (state_q == gbfs_pkg::S_IDLE);
	assign in_accept  = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign in_row_ext = gbfs_pkg::GRID_SZ_W'(in_data.row);
	assign in_col_ext = gbfs_pkg::GRID_SZ_W'(in_data.col);
	assign in_store   = (in_row_ext < gbfs_pkg::GRID_SZ_W'(MAX_ROWS)) &&
		(in_col_ext < gbfs_pkg::GRID_SZ_W'(MAX_COLS));
	assign in_grid    = (in_row_ext < rows_used) && (in_col_ext < cols_used);
	assign in_addr    = {in_row_ext[ROW_W-1:0], in_col_ext[COL_W-1:0]};

	assign clr_done   = &clr_q;
	assign fifo_empty = (head_q == tail_q);
	assign pop_go     = (state_q == gbfs_pkg::S_POP) && !nb.pending && !fifo_empty;
	assign out_free   = !out_valid_q || out_ready;
	assign fifo_dist  = fifo_rdata[gbfs_pkg::DIST_W-1:0];
	assign next_dist  = (fifo_dist == '1) ? fifo_dist : fifo_dist + 1'b1;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
		.clk   (clk),
		.we    (wall_we),
		.waddr (wall_waddr),
		.wdata (wall_wdata),
		.re    (wall_re),
		.raddr (wall_raddr),
		.rdata (wall_rdata)
	);

	gbfs_ram #(.WIDTH(VD_W), .DEPTH(CELLS)) u_vd_ram (
		.clk   (clk),
		.we    (vd_we),
		.waddr (vd_waddr),
		.wdata (vd_wdata),
		.re    (vd_re),
		.raddr (vd_raddr),
		.rdata (vd_rdata)
	);

	gbfs_ram #(.WIDTH(FIFO_W), .DEPTH(CELLS)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.re    (fifo_re),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	gbfs_nbr #(.ROW_W(ROW_W), .COL_W(COL_W)) u_gbfs_nbr (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (state_q == gbfs_pkg::S_NB),
		.cur_addr    (cur_addr_q),
		.dir         (dir_q),
		.rows_used   (rows_used),
		.cols_used   (cols_used),
		.wall_bit    (wall_rdata),
		.visited_bit (vd_rdata.visited),
		.rd_addr     (nb_addr),
		.push_addr   (push_addr),
		.stat        (nb)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbfs_pkg::S_INIT: begin
				if (clr_done)
					state_d = gbfs_pkg::S_IDLE;
			end
			gbfs_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (in_data.cmd)
						gbfs_pkg::CMD_RUN:   state_d = gbfs_pkg::S_CLEAR;
						gbfs_pkg::CMD_QUERY: state_d = in_grid ? gbfs_pkg::S_QWAIT : gbfs_pkg::S_DONE;
						default:             state_d = gbfs_pkg::S_DONE;
					endcase
				end
			end
			gbfs_pkg::S_CLEAR: begin
				if (clr_done)
					state_d = start_ok_q ? gbfs_pkg::S_START : gbfs_pkg::S_DONE;
			end
			gbfs_pkg::S_START: state_d = gbfs_pkg::S_POP;
			gbfs_pkg::S_POP: begin
				if (!nb.pending)
					state_d = fifo_empty ? gbfs_pkg::S_DONE : gbfs_pkg::S_FETCH;
			end
			gbfs_pkg::S_FETCH: state_d = gbfs_pkg::S_NB;
			gbfs_pkg::S_NB: begin
				if (dir_q == gbfs_pkg::DIR_LEFT)
					state_d = gbfs_pkg::S_POP;
			end
			gbfs_pkg::S_QWAIT: state_d = gbfs_pkg::S_DONE;
			gbfs_pkg::S_DONE: begin
				if (out_free)
					state_d = gbfs_pkg::S_IDLE;
			end
			default: state_d = gbfs_pkg::S_INIT;
		endcase
	end

	always_comb begin
		wall_we    = 1'b0;
		wall_waddr = clr_q;
		wall_wdata = 1'b0;
		wall_re    = 1'b0;
		wall_raddr = nb_addr;
		vd_we      = 1'b0;
		vd_waddr   = clr_q;
		vd_wdata   = '0;
		vd_re      = 1'b0;
		vd_raddr   = nb_addr;
		fifo_we    = 1'b0;
		fifo_waddr = tail_q[ADDR_W-1:0];
		fifo_wdata = {push_addr, nd_q};
		fifo_re    = 1'b0;
		fifo_raddr = head_q[ADDR_W-1:0];
		unique case (state_q)
			gbfs_pkg::S_INIT: begin
				wall_we = 1'b1;
				vd_we   = 1'b1;
			end
			gbfs_pkg::S_IDLE: begin
				if (in_accept && in_data.cmd == gbfs_pkg::CMD_WRITE && in_store) begin
					wall_we    = 1'b1;
					wall_waddr = in_addr;
					wall_wdata = in_data.wall;
				end
				if (in_accept && in_data.cmd == gbfs_pkg::CMD_QUERY && in_grid) begin
					vd_re    = 1'b1;
					vd_raddr = in_addr;
				end
			end
			gbfs_pkg::S_CLEAR: vd_we = 1'b1;
			gbfs_pkg::S_START: begin
				vd_we      = 1'b1;
				vd_waddr   = start_addr_q;
				vd_wdata   = '{visited: 1'b1, steps: '0};
				fifo_we    = 1'b1;
				fifo_wdata = {start_addr_q, {gbfs_pkg::DIST_W{1'b0}}};
			end
			gbfs_pkg::S_POP: fifo_re = pop_go;
			gbfs_pkg::S_NB: begin
				wall_re = nb.rd_en;
				vd_re   = nb.rd_en;
			end
			default: ;
		endcase
		if (nb.push) begin
			vd_we    = 1'b1;
			vd_waddr = push_addr;
			vd_wdata = '{visited: 1'b1, steps: nd_q};
			fifo_we  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbfs_pkg::S_INIT;
			rows_q      <= gbfs_pkg::GRID_SIZE_RESET;
			cols_q      <= gbfs_pkg::GRID_SIZE_RESET;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			dir_q       <= gbfs_pkg::DIR_UP;
			start_ok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					gbfs_pkg::REG_GRID_ROWS: rows_q <= cfg_data;
					gbfs_pkg::REG_GRID_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == gbfs_pkg::S_INIT || state_q == gbfs_pkg::S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (in_accept && in_data.cmd == gbfs_pkg::CMD_RUN) begin
				head_q     <= '0;
				tail_q     <= '0;
				start_ok_q <= in_grid;
			end
			if (state_q == gbfs_pkg::S_START)
				tail_q <= (ADDR_W+1)'(1);
			if (nb.push)
				tail_q <= tail_q + 1'b1;
			if (pop_go)
				head_q <= head_q + 1'b1;
			if (state_q == gbfs_pkg::S_FETCH)
				dir_q <= gbfs_pkg::DIR_UP;
			else if (state_q == gbfs_pkg::S_NB)
				dir_q <= gbfs_pkg::dir_t'(dir_q + 2'd1);
			if (state_q == gbfs_pkg::S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q        <= '0;
			start_addr_q <= in_addr;
		end
		if (state_q == gbfs_pkg::S_POP && !nb.pending && fifo_empty)
			res_q.reachable <= 1'b1;
		if (state_q == gbfs_pkg::S_QWAIT && vd_rdata.visited)
			res_q <= '{distance: vd_rdata.steps, reachable: 1'b1};
		if (state_q == gbfs_pkg::S_FETCH) begin
			cur_addr_q <= fifo_rdata[FIFO_W-1:gbfs_pkg::DIST_W];
			nd_q       <= next_dist;
		end
		if (state_q == gbfs_pkg::S_DONE && out_free)
			out_data_q <= res_q;
	end

endmodule

[hdl/gbfs_checker.sv]
// Port-level assertions of the grid breadth-first distance core and their bind.
module gbfs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input gbfs_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed or dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after an item was accepted");

	a_unreached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.reachable || out_data.distance == '0)
		else $error("unreached result carries a distance");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result item appeared while the core was idle");

	a_busy_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input ready dropped without an item");

endmodule

bind grid_bfs_distance_core gbfs_checker u_gbfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
